// ----- rtl/core/cbse_pkg.sv -----
`default_nettype none
package cbse_pkg;

  localparam int unsigned EdgeW  = 16;
  localparam int unsigned SpanW  = 18;
  localparam int unsigned UnitW  = 14;
  localparam int unsigned DistW  = 17;
  localparam int unsigned CountW = 4;
  localparam int unsigned ProdW  = UnitW + CountW;

  typedef struct packed {
    logic signed [EdgeW-1:0] child_top;
    logic signed [EdgeW-1:0] child_bottom;
    logic signed [EdgeW-1:0] child_left;
    logic signed [EdgeW-1:0] child_right;
    logic signed [EdgeW-1:0] parent_top;
    logic signed [EdgeW-1:0] parent_bottom;
    logic signed [EdgeW-1:0] parent_left;
    logic signed [EdgeW-1:0] parent_right;
  } in_word_t;

  typedef struct packed {
    logic [15:0]             box_code;
    logic signed [EdgeW-1:0] snapped_top;
    logic signed [EdgeW-1:0] snapped_bottom;
    logic signed [EdgeW-1:0] snapped_left;
    logic signed [EdgeW-1:0] snapped_right;
  } out_word_t;

  // one axis, one edge in flight
  typedef struct packed {
    logic                    active;
    logic [UnitW-1:0]        unit;
    logic [DistW-1:0]        gap;
    logic signed [EdgeW-1:0] pedge;
    logic signed [EdgeW-1:0] cedge;
    logic                    up;
    logic [CountW-1:0]       quo;
    logic [DistW-1:0]        rem;
  } edge_job_t;

endpackage
`default_nettype wire

// ----- rtl/core/child_bbox_sixteenth_encoder.sv -----
`default_nettype none
// child bounding box sixteenth encoder
// input word: start pulses with in_word while busy is low (busy is always low);
// one input word may be taken every cycle.
// each parent axis is cut into sixteenths; both child edges of both axes go
// through their own pipelined edge unit: setup, four restoring divide stages
// (one quotient bit each), a snap multiply and the final add, then the code
// and snapped box are packed into the output register.
// throughput: one word per cycle, set by the fully pipelined divide stages.
// result word is on out_word for exactly one cycle with done high; the
// receiver cannot stall, so nothing is held back.
// reset clears all valid bits; words in flight are dropped.
module child_bbox_sixteenth_encoder (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output      logic                 busy,
  input  wire cbse_pkg::in_word_t   in_word,
  output      logic                 done,
  output      cbse_pkg::out_word_t  out_word
);
  assign busy = 1'b0;
  logic go;
  assign go = start && !busy;

  cbse_pkg::edge_job_t jl, jr, jb, jt;
  logic [cbse_pkg::UnitW-1:0] ux, uy;
  logic [17:0] lx, ly;
  always_comb begin
    lx = 18'(in_word.parent_right) - 18'(in_word.parent_left) + 18'd15;
    ly = 18'(in_word.parent_top) - 18'(in_word.parent_bottom) + 18'd15;
    ux = lx[17:4];
    uy = ly[17:4];
    jl = '0; jr = '0; jb = '0; jt = '0;
    jl.unit = ux; jr.unit = ux; jb.unit = uy; jt.unit = uy;
    jl.gap = 17'(18'(in_word.child_left) - 18'(in_word.parent_left));
    jr.gap = 17'(18'(in_word.parent_right) - 18'(in_word.child_right));
    jb.gap = 17'(18'(in_word.child_bottom) - 18'(in_word.parent_bottom));
    jt.gap = 17'(18'(in_word.parent_top) - 18'(in_word.child_top));
    jl.active = !lx[17] && (lx >= 18'd16) &&
                $signed(18'(in_word.child_left) - 18'(in_word.parent_left)) > 0;
    jr.active = !lx[17] && (lx >= 18'd16) &&
                $signed(18'(in_word.parent_right) - 18'(in_word.child_right)) > 0;
    jb.active = !ly[17] && (ly >= 18'd16) &&
                $signed(18'(in_word.child_bottom) - 18'(in_word.parent_bottom)) > 0;
    jt.active = !ly[17] && (ly >= 18'd16) &&
                $signed(18'(in_word.parent_top) - 18'(in_word.child_top)) > 0;
    jl.up = 1'b1; jb.up = 1'b1;
    jl.pedge = in_word.parent_left;   jl.cedge = in_word.child_left;
    jr.pedge = in_word.parent_right;  jr.cedge = in_word.child_right;
    jb.pedge = in_word.parent_bottom; jb.cedge = in_word.child_bottom;
    jt.pedge = in_word.parent_top;    jt.cedge = in_word.child_top;
  end

  logic vl, vr, vb, vt;
  logic [3:0] cl, cr, cb, ct;
  logic signed [15:0] sl, sr, sb, st;
  cbse_edge u_l (.clk, .rst, .vin(go), .jin(jl), .vout(vl), .count(cl), .snapped(sl));
  cbse_edge u_r (.clk, .rst, .vin(go), .jin(jr), .vout(vr), .count(cr), .snapped(sr));
  cbse_edge u_b (.clk, .rst, .vin(go), .jin(jb), .vout(vb), .count(cb), .snapped(sb));
  cbse_edge u_t (.clk, .rst, .vin(go), .jin(jt), .vout(vt), .count(ct), .snapped(st));

  always_ff @(posedge clk) begin
    done <= rst ? 1'b0 : (vl & vr & vb & vt);
    out_word.box_code       <= {cr, cl, ct, cb};
    out_word.snapped_top    <= st;
    out_word.snapped_bottom <= sb;
    out_word.snapped_left   <= sl;
    out_word.snapped_right  <= sr;
  end
endmodule
`default_nettype wire

// ----- rtl/core/cbse_divstep.sv -----
`default_nettype none
// one restoring quotient bit per stage, msb first; early-out at 16 handled by sat flag
module cbse_divstep (
  input  wire logic                       clk,
  input  wire logic                       vin,
  input  wire cbse_pkg::edge_job_t        jin,
  input  wire logic [1:0]                 bitpos,
  output      logic                       vout,
  output      cbse_pkg::edge_job_t        jout
);
  cbse_pkg::edge_job_t j;
  logic [cbse_pkg::DistW+3:0] sh;
  always_comb begin
    j = jin;
    sh = {4'b0, cbse_pkg::DistW'(jin.unit)} << bitpos;
    if ({4'b0, jin.rem} >= sh) begin
      j.rem = cbse_pkg::DistW'({4'b0, jin.rem} - sh);
      j.quo[bitpos] = 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    vout <= vin;
    jout <= j;
  end
endmodule
`default_nettype wire

// ----- rtl/core/cbse_edge.sv -----
`default_nettype none
// prep, four divide steps, snap multiply, final add
module cbse_edge (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     vin,
  input  wire cbse_pkg::edge_job_t      jin,
  output      logic                     vout,
  output      logic [3:0]               count,
  output      logic signed [15:0]       snapped
);
  wire [4:0] v;
  cbse_pkg::edge_job_t j [5];
  cbse_pkg::edge_job_t j0, jq;
  logic vq;
  logic sat0;
  logic [3:0] sat_d;
  logic sat;

  always_comb begin
    j0 = jin;
    j0.quo = '0;
    j0.rem = jin.gap;
  end

  // quotient >= 16 saturates; check with a compare against 16*unit
  always_ff @(posedge clk) begin
    vq   <= rst ? 1'b0 : vin;
    jq   <= j0;
    sat0 <= (({4'b0, jin.unit} << 4) <= {1'b0, jin.gap});
  end
  assign v[0] = vq;
  assign j[0] = jq;

  always_ff @(posedge clk) begin
    sat_d <= {sat_d[2:0], sat0};
  end
  assign sat = sat_d[3];

  genvar g;
  for (g = 0; g < 4; g++) begin : g_step
    logic vo;
    cbse_divstep u_step (
      .clk(clk), .vin(v[g]), .jin(j[g]), .bitpos(2'(3 - g)), .vout(vo), .jout(j[g+1])
    );
    assign v[g+1] = rst ? 1'b0 : vo;
  end

  logic [3:0] n;
  always_comb n = !j[4].active ? 4'd0 : (sat ? 4'd15 : j[4].quo);

  logic [cbse_pkg::ProdW-1:0] prod;
  logic signed [15:0] pe, ce;
  logic up, act, vm;
  logic [3:0] nm;
  always_ff @(posedge clk) begin
    vm   <= rst ? 1'b0 : v[4];
    prod <= j[4].unit * n;
    pe   <= j[4].pedge;
    ce   <= j[4].cedge;
    up   <= j[4].up;
    act  <= j[4].active;
    nm   <= n;
  end

  logic signed [18:0] s;
  always_comb s = up ? 19'(pe) + $signed({1'b0, prod}) : 19'(pe) - $signed({1'b0, prod});
  always_ff @(posedge clk) begin
    vout    <= rst ? 1'b0 : vm;
    count   <= nm;
    snapped <= act ? s[15:0] : ce;
  end
endmodule
`default_nettype wire

// ----- rtl/core/cbse_checker.sv -----
`default_nettype none
module cbse_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                done,
  input wire cbse_pkg::in_word_t  in_word,
  input wire cbse_pkg::out_word_t out_word
);
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##8 done) else $error("missing result word");
  a_nospur: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 8)) else $error("spurious result word");
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
  a_rst: assert property (@(posedge clk) rst |=> !done) else $error("done after reset");
endmodule
bind child_bbox_sixteenth_encoder cbse_checker u_chk (.*);
`default_nettype wire

// ----- tb/child_bbox_sixteenth_encoder_checker.sv -----
`default_nettype none
module child_bbox_sixteenth_encoder_checker (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire cbse_pkg::in_word_t  in_word,
  input  wire logic                done,
  input  wire cbse_pkg::out_word_t out_word,
  output int                       fail_count,
  output int                       pending
);
  import cbse_pkg::*;

  out_word_t snap_q[$];

  // one axis: returns the code byte and updates the child edges
  function automatic logic [7:0] code_axis(inout int lo, inout int hi, input int plo,
                                           input int phi);
    int span;
    int unit;
    int d;
    int n;
    int p;
    n = 0;
    p = 0;
    span = phi - plo + 15;
    if (span < 16) return 8'h00;
    unit = span / 16;
    d = lo - plo;
    if (d > 0) begin
      n = d / unit;
      if (n > 15) n = 15;
      lo = plo + n * unit;
    end
    d = phi - hi;
    if (d > 0) begin
      p = d / unit;
      if (p > 15) p = 15;
      hi = phi - p * unit;
    end
    return {p[3:0], n[3:0]};
  endfunction

  function automatic out_word_t snap_box(in_word_t w);
    out_word_t r;
    int t;
    int b;
    int l;
    int rt;
    t = w.child_top;
    b = w.child_bottom;
    l = w.child_left;
    rt = w.child_right;
    r.box_code[15:8] = code_axis(l, rt, w.parent_left, w.parent_right);
    r.box_code[7:0] = code_axis(b, t, w.parent_bottom, w.parent_top);
    r.snapped_top = t[15:0];
    r.snapped_bottom = b[15:0];
    r.snapped_left = l[15:0];
    r.snapped_right = rt[15:0];
    return r;
  endfunction

  assign pending = snap_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    out_word_t e;
    if (!rst) begin
      if (start && !busy) snap_q.push_back(snap_box(in_word));
      if (done) begin
        if (snap_q.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_word);
          fail_count <= fail_count + 1;
        end else begin
          e = snap_q.pop_front();
          if (e.box_code !== out_word.box_code)
            $display("%0t: box_code exp %h got %h", $time, e.box_code, out_word.box_code);
          if (e.snapped_top !== out_word.snapped_top)
            $display("%0t: snapped_top exp %0d got %0d", $time, e.snapped_top,
                     out_word.snapped_top);
          if (e.snapped_bottom !== out_word.snapped_bottom)
            $display("%0t: snapped_bottom exp %0d got %0d", $time, e.snapped_bottom,
                     out_word.snapped_bottom);
          if (e.snapped_left !== out_word.snapped_left)
            $display("%0t: snapped_left exp %0d got %0d", $time, e.snapped_left,
                     out_word.snapped_left);
          if (e.snapped_right !== out_word.snapped_right)
            $display("%0t: snapped_right exp %0d got %0d", $time, e.snapped_right,
                     out_word.snapped_right);
          if (e !== out_word) fail_count <= fail_count + 1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- tb/child_bbox_sixteenth_encoder_tb.sv -----
`default_nettype none
module child_bbox_sixteenth_encoder_tb;
  import cbse_pkg::*;

  localparam int NumRandom = 1530;
  localparam int Latency = 8;
  localparam int CycleLimit = 200000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      done;
  out_word_t out_word;
  int        fail_count;
  int        pending;
  int        cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  child_bbox_sixteenth_encoder dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_word(in_word), .done(done), .out_word(out_word)
  );

  child_bbox_sixteenth_encoder_checker chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_word(in_word),
    .done(done), .out_word(out_word), .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // hold start high until the word is taken
  task automatic send_word(in_word_t w, bit may_idle);
    while (may_idle && $urandom_range(99) < 33) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [15:0] edge_value(int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly boxes where the child sits inside a sane parent
  function automatic in_word_t rand_word();
    in_word_t w;
    int plo;
    int phi;
    int span;
    int a;
    int b;
    int k;
    if ($urandom_range(9) < 2) begin
      w = {$urandom, $urandom, $urandom, $urandom};
      if ($urandom_range(3) == 0) w.parent_left = edge_value($urandom_range(5));
      if ($urandom_range(3) == 0) w.child_right = edge_value($urandom_range(5));
      return w;
    end
    for (k = 0; k < 2; k++) begin
      case ($urandom_range(3))
        0: span = $urandom_range(20);
        1: span = $urandom_range(400);
        2: span = $urandom_range(65535);
        default: span = 240 + $urandom_range(20);
      endcase
      plo = -32768 + $urandom_range(65535 - span);
      phi = plo + span;
      a = plo - 3 + $urandom_range(span + 6);
      b = plo - 3 + $urandom_range(span + 6);
      if (a < -32768) a = -32768;
      if (b > 32767) b = 32767;
      if (k == 0) begin
        w.parent_left = plo[15:0];
        w.parent_right = phi[15:0];
        w.child_left = a[15:0];
        w.child_right = b[15:0];
      end else begin
        w.parent_bottom = plo[15:0];
        w.parent_top = phi[15:0];
        w.child_bottom = a[15:0];
        w.child_top = b[15:0];
      end
    end
    return w;
  endfunction

  initial begin
    in_word_t w;
    int i;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: extremes, degenerate and inverted parents, children outside
    for (i = 0; i < 16; i++) begin
      w.child_top = edge_value(i % 4);
      w.child_bottom = edge_value((i / 4) % 4);
      w.child_left = edge_value((i + 1) % 4);
      w.child_right = edge_value((i + 2) % 4);
      w.parent_top = edge_value((i + 3) % 4);
      w.parent_bottom = edge_value(i / 4);
      w.parent_left = edge_value((i / 2) % 4);
      w.parent_right = edge_value((i + 1) / 2 % 4);
      send_word(w, 1'b0);
    end
    send_word({16'sd100, 16'sd0, 16'sd0, 16'sd100, 16'sd100, 16'sd0, 16'sd0, 16'sd100},
              1'b0);
    send_word({16'sd50, 16'sd50, 16'sd50, 16'sd50, 16'sd50, 16'sd50, 16'sd50, 16'sd50},
              1'b0);
    send_word({16'sd7, 16'sd3, 16'sd3, 16'sd7, 16'sd10, 16'sd0, 16'sd0, 16'sd1}, 1'b0);
    send_word({16'sd300, -16'sd300, -16'sd300, 16'sd300, 16'sd200, -16'sd200,
               -16'sd200, 16'sd200}, 1'b0);
    send_word({16'sd140, 16'sd9, 16'sd9, 16'sd140, 16'sd160, 16'sd0, 16'sd0, 16'sd160},
              1'b0);
    start <= 1'b0;
    // let everything drain once before the random part
    while (pending != 0) @(posedge clk);
    for (i = 0; i < NumRandom; i++) begin
      send_word(rand_word(), !(i >= 400 && i < 700));
    end
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
